[rtl/core/combined_lcg_shuffle_rng_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the combined LCG shuffle generator
// Clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH

// condition must hold at every clock edge out of reset
`define CLSR_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CLSR_IMPLIES_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/clsr_pkg.sv]
// ----------------------------------------------------------------------------
// clsr_pkg
// Widths and constants of the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
package clsr_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int WARMUP      = 8;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + WARMUP);

    localparam int VAL_W  = 31;
    localparam int FRAC_W = 24;
    localparam int MUL_W  = 16;
    localparam int PROD_W = VAL_W + MUL_W;

    // both moduli sit just below 2^31: fold the high part back by the gap
    localparam logic [31:0] GAP1 = 32'd85;
    localparam logic [31:0] GAP2 = 32'd249;
    localparam logic [31:0] MOD1 = 32'h8000_0000 - GAP1;
    localparam logic [31:0] MOD2 = 32'h8000_0000 - GAP2;
    localparam logic [31:0] RAW_MAX = MOD1 - 32'd1;

    localparam logic [MUL_W-1:0] MUL1 = 16'd40014;
    localparam logic [MUL_W-1:0] MUL2 = 16'd40692;

    localparam logic [31:0] SLOT_DIV = 32'(1 + (MOD1 - 1) / TABLE_DEPTH);

    localparam logic [VAL_W-1:0] SEED_RST = 31'd1;
    localparam logic [VAL_W-1:0] GEN2_RST = 31'd123456789;

endpackage

[rtl/core/combined_lcg_shuffle_rng.sv]
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Two multiplicative congruential generators combined through a shuffle table.
// ----------------------------------------------------------------------------
// A draw is requested by one transfer on the input channel; i_reseed = 1 asks
// for the generators and the shuffle table to be rebuilt from the seed register
// first, and the very first draw after reset always rebuilds. Each draw yields
// one transfer on the output channel carrying the 31-bit combined value and its
// 0.24 fraction of the first modulus. A new draw is taken only once the one
// before it has issued its result. The steps are set by the microcode: every
// generator step is a multiply step followed by a fold step, a rebuild loads
// the seed and runs TABLE_DEPTH+8 such warm-up and fill steps one after
// another, and a draw walks the slot, table read-modify-write, combine and
// issue steps in turn. A finished result waits in the output register while
// the next draw is already taken. The seed register may be written at any
// time the block is idle; a write takes effect at the next rebuild.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // draw request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_reseed,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [clsr_pkg::VAL_W-1:0]  o_raw_value,
    output logic [clsr_pkg::FRAC_W-1:0] o_fraction,
    // seed register write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [clsr_pkg::VAL_W-1:0]  i_cfg_seed_magnitude
);

    import clsr_pkg::*;

    // ------------------------------------------------------------------
    // Microprogram: step names, operations and jump conditions
    // ------------------------------------------------------------------
    typedef enum logic [3:0] {
        ST_IDLE,        // wait for a draw request
        ST_ROUTE,       // skip the rebuild when not needed
        ST_LOAD,        // load seed into both generators
        ST_INIT_MUL,    // warm-up / fill: multiply
        ST_INIT_FOLD,   // warm-up / fill: fold, store, loop
        ST_DRAW_MUL,    // draw: multiply both generators, pick slot
        ST_DRAW_FOLD,   // draw: fold, table read-modify-write
        ST_COMBINE,     // draw: combine table word with second generator
        ST_EMIT         // draw: issue result, wait while output is full
    } t_step;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD,
        OP_INIT_MUL,
        OP_INIT_FOLD,
        OP_DRAW_MUL,
        OP_DRAW_FOLD,
        OP_COMBINE,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEXT,         // never jump
        C_NO_INPUT,     // jump while no request is taken
        C_SKIP_INIT,    // jump when tables are valid and no reseed asked
        C_LOOP,         // jump while the step counter is not zero
        C_BLOCKED       // jump while the output register cannot be loaded
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_ctrl;

    localparam t_step LAST_STEP = ST_EMIT;

    function automatic t_ctrl prog_word(input t_step s);
        t_ctrl w;
        w = '{op: OP_NONE, cond: C_NEXT, target: ST_IDLE};
        unique case (s)
            ST_IDLE:      w = '{op: OP_ACCEPT,    cond: C_NO_INPUT,  target: ST_IDLE};
            ST_ROUTE:     w = '{op: OP_NONE,      cond: C_SKIP_INIT, target: ST_DRAW_MUL};
            ST_LOAD:      w = '{op: OP_LOAD,      cond: C_NEXT,      target: ST_IDLE};
            ST_INIT_MUL:  w = '{op: OP_INIT_MUL,  cond: C_NEXT,      target: ST_IDLE};
            ST_INIT_FOLD: w = '{op: OP_INIT_FOLD, cond: C_LOOP,      target: ST_INIT_MUL};
            ST_DRAW_MUL:  w = '{op: OP_DRAW_MUL,  cond: C_NEXT,      target: ST_IDLE};
            ST_DRAW_FOLD: w = '{op: OP_DRAW_FOLD, cond: C_NEXT,      target: ST_IDLE};
            ST_COMBINE:   w = '{op: OP_COMBINE,   cond: C_NEXT,      target: ST_IDLE};
            ST_EMIT:      w = '{op: OP_EMIT,      cond: C_BLOCKED,   target: ST_EMIT};
            default:      w = '{op: OP_NONE,      cond: C_NEXT,      target: ST_IDLE};
        endcase
        return w;
    endfunction

    // fold p = hi*2^31 + lo modulo (2^31 - gap): hi*gap + lo stays below 2m
    function automatic logic [VAL_W-1:0] mod_fold(input logic [PROD_W-1:0] p,
                                                  input logic [31:0] gap,
                                                  input logic [31:0] m);
        logic [31:0] s;
        s = {1'b0, p[VAL_W-1:0]} + 32'(p[PROD_W-1:VAL_W]) * gap;
        if (s >= m) begin
            s = s - m;
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic logic [31:0] slot_thr(input int k);
        return 32'(k) * SLOT_DIV;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_step              r_pc;
    logic               r_req;          // reseed flag of the draw in hand
    logic               r_init;         // table holds a valid fill
    logic [CNT_W-1:0]   r_cnt;          // remaining warm-up / fill steps
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_raw;
    logic [FRAC_W-1:0]  r_out_frac;

    logic [VAL_W-1:0]   r_seed;
    logic [VAL_W-1:0]   r_g1;
    logic [VAL_W-1:0]   r_g2;
    logic [PROD_W-1:0]  r_p1;
    logic [PROD_W-1:0]  r_p2;
    logic [VAL_W-1:0]   r_last;
    logic [SLOT_W-1:0]  r_slot;
    logic [VAL_W-1:0]   r_rd;
    logic [VAL_W-1:0]   r_table [TABLE_DEPTH];

    t_step              n_pc;

    // ------------------------------------------------------------------
    // Control decode
    // ------------------------------------------------------------------
    t_ctrl              ctrl;
    logic               in_take;
    logic               out_blocked;
    logic               emit;
    logic               jump;

    assign ctrl        = prog_word(r_pc);
    assign in_take     = i_valid && (ctrl.op == OP_ACCEPT);
    assign out_blocked = r_out_valid && i_stall;
    assign emit        = (ctrl.op == OP_EMIT) && !out_blocked;

    always_comb begin
        unique case (ctrl.cond)
            C_NEXT:      jump = 1'b0;
            C_NO_INPUT:  jump = !in_take;
            C_SKIP_INIT: jump = r_init && !r_req;
            C_LOOP:      jump = (r_cnt != '0);
            C_BLOCKED:   jump = out_blocked;
            default:     jump = 1'b0;
        endcase
    end

    always_comb begin
        if (jump) begin
            n_pc = ctrl.target;
        end else if (r_pc == LAST_STEP) begin
            n_pc = ST_IDLE;
        end else begin
            n_pc = t_step'(r_pc + 4'd1);
        end
    end

    // ------------------------------------------------------------------
    // Datapath logic
    // ------------------------------------------------------------------
    logic [VAL_W-1:0]   fold1;
    logic [VAL_W-1:0]   fold2;
    logic [VAL_W-1:0]   seed_eff;
    logic [SLOT_W-1:0]  slot_calc;
    logic [VAL_W+1:0]   diff;
    logic [VAL_W+1:0]   diff_wrap;
    logic [VAL_W-1:0]   combined;
    logic [FRAC_W-1:0]  frac_q0;
    logic [FRAC_W:0]    frac_q1;
    logic [55:0]        frac_lhs;
    logic [55:0]        frac_rhs;
    logic [FRAC_W:0]    frac_sel;
    logic [FRAC_W-1:0]  frac_calc;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;

    assign fold1    = mod_fold(r_p1, GAP1, MOD1);
    assign fold2    = mod_fold(r_p2, GAP2, MOD2);
    assign seed_eff = (r_seed == '0) ? VAL_W'(1) : r_seed;

    // slot = last / SLOT_DIV, saturated: count the thresholds passed
    always_comb begin
        slot_calc = '0;
        for (int k = 1; k < TABLE_DEPTH; k++) begin
            if ({1'b0, r_last} >= slot_thr(k)) begin
                slot_calc = SLOT_W'(k);
            end
        end
    end

    // table word minus second generator, wrapped into 1 .. MOD1-1
    assign diff      = {2'b00, r_rd} - {2'b00, r_g2};
    assign diff_wrap = diff + (VAL_W+2)'(RAW_MAX);
    assign combined  = (diff[VAL_W+1] || (diff == '0)) ? diff_wrap[VAL_W-1:0]
                                                        : diff[VAL_W-1:0];

    // fraction is last>>7 or one more: test last*2^24 >= (q0+1)*MOD1
    assign frac_q0   = r_last[VAL_W-1 -: FRAC_W];
    assign frac_q1   = {1'b0, frac_q0} + (FRAC_W+1)'(1);
    assign frac_lhs  = {1'b0, r_last, {FRAC_W{1'b0}}} + 56'(frac_q1) * 56'(GAP1);
    assign frac_rhs  = {frac_q1, {VAL_W{1'b0}}};
    assign frac_sel  = (frac_lhs >= frac_rhs) ? frac_q1 : {1'b0, frac_q0};
    assign frac_calc = frac_sel[FRAC_W] ? {FRAC_W{1'b1}} : frac_sel[FRAC_W-1:0];

    // fill writes run from the top slot down; a draw refills the slot it read
    assign mem_we    = ((ctrl.op == OP_INIT_FOLD) && (r_cnt < CNT_W'(TABLE_DEPTH)))
                    || (ctrl.op == OP_DRAW_FOLD);
    assign mem_waddr = (ctrl.op == OP_INIT_FOLD) ? r_cnt[SLOT_W-1:0] : r_slot;

    // ------------------------------------------------------------------
    // Sequencer state and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= ST_IDLE;
            r_req       <= 1'b0;
            r_init      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_out_raw   <= '0;
            r_out_frac  <= '0;
        end else begin
            r_pc <= n_pc;
            if (in_take) begin
                r_req <= i_reseed;
            end
            if (ctrl.op == OP_LOAD) begin
                r_cnt <= CNT_W'(TABLE_DEPTH + WARMUP - 1);
            end else if (ctrl.op == OP_INIT_FOLD) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_init <= 1'b1;
                end
            end
            // load a new result, or drop the old one once transferred
            if (emit) begin
                r_out_valid <= 1'b1;
                r_out_raw   <= r_last;
                r_out_frac  <= frac_calc;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Generator datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RST;
            r_g1   <= '0;
            r_g2   <= GEN2_RST;
            r_last <= '0;
            r_slot <= '0;
            r_p1   <= '0;
            r_p2   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_seed <= i_cfg_seed_magnitude;
            end
            unique case (ctrl.op)
                OP_LOAD: begin
                    r_g1 <= seed_eff;
                    r_g2 <= seed_eff;
                end
                OP_INIT_MUL: begin
                    r_p1 <= PROD_W'(r_g1) * PROD_W'(MUL1);
                end
                OP_INIT_FOLD: begin
                    r_g1 <= fold1;
                    // the final fill value lands in slot 0 and seeds last
                    if (r_cnt == '0) begin
                        r_last <= fold1;
                    end
                end
                OP_DRAW_MUL: begin
                    r_p1   <= PROD_W'(r_g1) * PROD_W'(MUL1);
                    r_p2   <= PROD_W'(r_g2) * PROD_W'(MUL2);
                    r_slot <= slot_calc;
                end
                OP_DRAW_FOLD: begin
                    r_g1 <= fold1;
                    r_g2 <= fold2;
                end
                OP_COMBINE: begin
                    r_last <= combined;
                end
                OP_NONE, OP_ACCEPT, OP_EMIT: begin
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shuffle table: read-before-write on the draw slot
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= fold1;
        end
        if (ctrl.op == OP_DRAW_FOLD) begin
            r_rd <= r_table[r_slot];
        end
    end

    assign o_stall     = (ctrl.op != OP_ACCEPT);
    assign o_valid     = r_out_valid;
    assign o_raw_value = r_out_raw;
    assign o_fraction  = r_out_frac;
    assign o_cfg_ready = 1'b1;

endmodule

[rtl/core/clsr_checker.sv]
// ----------------------------------------------------------------------------
// clsr_checker
// Port-level checks on the result channel of the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
`include "combined_lcg_shuffle_rng_macros.svh"

module clsr_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_valid,
    input  logic                        i_stall,
    input  logic [clsr_pkg::VAL_W-1:0]  o_raw_value,
    input  logic [clsr_pkg::FRAC_W-1:0] o_fraction
);

    import clsr_pkg::*;

    // hold a stalled result
    `CLSR_IMPLIES_NEXT(a_valid_held, o_valid && i_stall, o_valid, "result dropped while stalled")
    `CLSR_IMPLIES_NEXT(a_payload_held, o_valid && i_stall, $stable(o_raw_value) && $stable(o_fraction), "stalled result changed")

    // combined value always lies in 1 .. MOD1-1
    `CLSR_HOLDS(a_raw_range, !o_valid || ((o_raw_value != '0) && (32'(o_raw_value) <= RAW_MAX)), "raw value out of range")

    // fraction tracks the top bits of the raw value within one step
    `CLSR_HOLDS(a_frac_track, !o_valid || (25'(o_fraction) == 25'(o_raw_value[VAL_W-1 -: FRAC_W])) || (25'(o_fraction) == 25'(o_raw_value[VAL_W-1 -: FRAC_W]) + 25'd1), "fraction does not match raw value")

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for combined_lcg_shuffle_rng
// Sends draw requests and seed register writes from a request queue and
// predicts every draw with its own two-generator shuffle model. Each result
// transfer is checked field by field against the oldest predicted draw.
// Both channels idle and stall at random. The run also has long holds on the
// result side and pauses on the request side.
// ----------------------------------------------------------------------------
module tb_top;
    import clsr_pkg::*;

    typedef enum logic [1:0] {
        REQ_DRAW,
        REQ_SEED,
        REQ_DRAIN
    } req_kind_e;

    typedef struct {
        req_kind_e      kind;
        logic           reseed;
        logic [VAL_W-1:0] seed;
        int unsigned    gap;
    } request_t;

    typedef struct {
        logic [VAL_W-1:0]  raw;
        logic [FRAC_W-1:0] frac;
    } draw_out_t;

    // ------------------------------------------------------------------
    // DUT signals: every input starts from a known value
    // ------------------------------------------------------------------
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_reseed = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [VAL_W-1:0]  o_raw_value;
    logic [FRAC_W-1:0] o_fraction;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [VAL_W-1:0]  i_cfg_seed_magnitude = '0;

    combined_lcg_shuffle_rng i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_reseed             (i_reseed),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_raw_value          (o_raw_value),
        .o_fraction           (o_fraction),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_seed_magnitude (i_cfg_seed_magnitude)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    request_t  request_fifo[$];
    draw_out_t draw_outputs_q[$];
    request_t  cur_req;
    bit        req_loaded = 1'b0;
    int unsigned req_gap = 0;

    // transfers seen at the last rising edge, for the falling-edge drivers
    bit        in_xfer = 1'b0;
    bit        cfg_xfer = 1'b0;
    bit        out_xfer = 1'b0;

    int        rx_count = 0;
    int        rx_wait = 0;
    int        rx_hold = 0;
    int        err_count = 0;

    // predictor copy of the generator state and the seed register
    logic [VAL_W-1:0] seed_reg = SEED_RST;
    logic [VAL_W-1:0] gen_a = '0;
    logic [VAL_W-1:0] gen_b = GEN2_RST;
    logic [VAL_W-1:0] last_val = '0;
    logic [VAL_W-1:0] shuffle[TABLE_DEPTH];
    bit               table_filled = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [VAL_W-1:0] lcg_step(input logic [VAL_W-1:0] v,
                                                  input logic [MUL_W-1:0] mul,
                                                  input logic [31:0] modulus);
        bit [63:0] prod;
        prod = 64'(v) * 64'(mul);
        return VAL_W'(prod % 64'(modulus));
    endfunction

    // Advance the generators by one draw and queue the value it must give.
    task automatic compute_draw(input logic reseed);
        logic [VAL_W-1:0] s;
        int               n;
        int unsigned      slot;
        longint           combined;
        bit [63:0]        frac;
        draw_out_t        r;
        // rebuild on request, and always on the first draw after reset
        if (reseed || !table_filled) begin
            s = (seed_reg == '0) ? VAL_W'(1) : seed_reg;
            gen_b = s;
            for (n = TABLE_DEPTH + WARMUP - 1; n >= 0; n--) begin
                s = lcg_step(s, MUL1, MOD1);
                if (n < TABLE_DEPTH)
                    shuffle[n] = s;
            end
            gen_a = s;
            last_val = shuffle[0];
            table_filled = 1'b1;
        end
        gen_a = lcg_step(gen_a, MUL1, MOD1);
        gen_b = lcg_step(gen_b, MUL2, MOD2);
        slot = last_val / SLOT_DIV;
        if (slot >= TABLE_DEPTH)
            slot = TABLE_DEPTH - 1;
        combined = longint'(shuffle[slot]) - longint'(gen_b);
        shuffle[slot] = gen_a;
        if (combined < 1)
            combined += longint'(RAW_MAX);
        last_val = combined[VAL_W-1:0];
        frac = ({33'd0, last_val} << FRAC_W) / 64'(MOD1);
        if (frac > 64'hFF_FFFF)
            frac = 64'hFF_FFFF;
        r.raw = last_val;
        r.frac = frac[FRAC_W-1:0];
        draw_outputs_q.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        err_count++;
        $display("MISMATCH at result %0d: %s got %0d want %0d",
                 rx_count, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Request side, rising edge: note transfers and run the predictor.
    // A seed write lands in the predictor's register at the same edge as
    // in the DUT; draws can only follow it since writes wait for idle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_xfer  <= i_rst_n && i_valid && !o_stall;
        cfg_xfer <= i_rst_n && i_cfg_valid && o_cfg_ready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                seed_reg = i_cfg_seed_magnitude;
            if (i_valid && !o_stall)
                compute_draw(i_reseed);
        end
    end

    // ------------------------------------------------------------------
    // Request driver, falling edge. Drop valid after a transfer unless the
    // next draw is due at once; hold seed writes and drains until every
    // predicted draw has come back.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_requests
        logic next_valid;
        logic next_cfg;
        next_valid = i_valid && !in_xfer;
        next_cfg   = i_cfg_valid && !cfg_xfer;
        if (i_rst_n && !next_valid && !next_cfg) begin
            if (!req_loaded && request_fifo.size() > 0) begin
                cur_req    = request_fifo.pop_front();
                req_loaded = 1'b1;
                req_gap    = cur_req.gap;
            end
            if (req_loaded) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else begin
                    case (cur_req.kind)
                        REQ_DRAW: begin
                            next_valid = 1'b1;
                            i_reseed <= cur_req.reseed;
                            req_loaded = 1'b0;
                        end
                        REQ_SEED: begin
                            if (draw_outputs_q.size() == 0) begin
                                next_cfg = 1'b1;
                                i_cfg_seed_magnitude <= cur_req.seed;
                                req_loaded = 1'b0;
                            end
                        end
                        default: begin
                            if (draw_outputs_q.size() == 0)
                                req_loaded = 1'b0;
                        end
                    endcase
                end
            end
        end
        i_valid     <= next_valid;
        i_cfg_valid <= next_cfg;
    end

    // ------------------------------------------------------------------
    // Result monitor, rising edge: compare each transfer with the oldest
    // predicted draw.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        draw_out_t want;
        out_xfer <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            rx_count++;
            if (draw_outputs_q.size() == 0) begin
                report_mismatch("result with no draw outstanding, raw_value",
                                o_raw_value, 0);
            end else begin
                want = draw_outputs_q.pop_front();
                if (o_raw_value !== want.raw)
                    report_mismatch("raw_value", o_raw_value, want.raw);
                if (o_fraction !== want.frac)
                    report_mismatch("fraction", o_fraction, want.frac);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result stall driver, falling edge. After each transfer draw a wait;
    // every third stretch of 150 results runs with no stall at all. Twice
    // in the run hold the stall so the DUT fills and stalls its request
    // side while the driver keeps offering.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_result_stall
        if (out_xfer) begin
            rx_wait = ((rx_count / 150) % 3 == 0) ? 0 : $urandom_range(0, 11);
            if (rx_count == 300 || rx_count == 1100)
                rx_hold = 400;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    task automatic push_draw(input logic reseed, input int unsigned gap);
        request_t r;
        r.kind = REQ_DRAW;
        r.reseed = reseed;
        r.seed = '0;
        r.gap = gap;
        request_fifo.push_back(r);
    endtask

    task automatic push_seed(input logic [VAL_W-1:0] seed);
        request_t r;
        r.kind = REQ_SEED;
        r.reseed = 1'b0;
        r.seed = seed;
        r.gap = $urandom_range(0, 11);
        request_fifo.push_back(r);
    endtask

    task automatic push_drain();
        request_t r;
        r.kind = REQ_DRAIN;
        r.reseed = 1'b0;
        r.seed = '0;
        r.gap = 0;
        request_fifo.push_back(r);
    endtask

    initial begin : stimulus
        logic [VAL_W-1:0] seed;
        int unsigned      gap;
        int               i;

        // first draw after reset rebuilds from the reset seed
        push_draw(1'b0, $urandom_range(0, 11));
        push_draw(1'b0, 0);
        push_draw(1'b0, 0);
        push_draw(1'b1, $urandom_range(0, 11));
        push_draw(1'b0, 0);
        // zero seed counts as one; a write alone must not rebuild
        push_seed('0);
        push_draw(1'b0, $urandom_range(0, 11));
        push_draw(1'b1, $urandom_range(0, 11));
        push_draw(1'b0, 0);
        // largest seed in range
        push_seed(VAL_W'(RAW_MAX));
        push_draw(1'b1, 0);
        push_draw(1'b0, 0);
        // seed equal to the second modulus leaves that generator at zero
        push_seed(VAL_W'(MOD2));
        push_draw(1'b1, $urandom_range(0, 11));
        push_draw(1'b0, 0);
        push_draw(1'b0, 0);
        // seed equal to the first modulus zeroes the first generator
        push_seed(VAL_W'(MOD1));
        push_draw(1'b1, 0);
        push_draw(1'b0, 0);
        // all ones, beyond both moduli
        push_seed({VAL_W{1'b1}});
        push_draw(1'b1, $urandom_range(0, 11));
        push_draw(1'b0, 0);
        push_draw(1'b0, $urandom_range(0, 11));

        // random part: mostly plain draws, the odd rebuild, and every
        // 160 items a pause for all results followed by a new seed
        for (i = 0; i < 1600; i++) begin
            if (i % 160 == 80) begin
                push_drain();
                case ($urandom_range(0, 7))
                    0:       seed = '0;
                    1:       seed = VAL_W'(RAW_MAX);
                    2:       seed = VAL_W'(MOD2);
                    3:       seed = SEED_RST;
                    default: seed = VAL_W'($urandom());
                endcase
                push_seed(seed);
            end
            gap = ((i / 200) % 4 == 1) ? 0 : $urandom_range(0, 11);
            push_draw($urandom_range(0, 19) == 0, gap);
        end

        // reset once, then let the drivers run
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (request_fifo.size() > 0 || req_loaded || i_valid || i_cfg_valid
               || draw_outputs_q.size() > 0);
        // allow a full rebuild's worth of cycles for any stray result
        repeat (200) @(negedge i_clk);

        if (err_count == 0)
            $display("combined_lcg_shuffle_rng test passed");
        else
            $display("combined_lcg_shuffle_rng test failed");
        $finish;
    end

    // hard limit well beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("combined_lcg_shuffle_rng test failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/clsr_pkg.sv
rtl/core/combined_lcg_shuffle_rng.sv
rtl/core/clsr_checker.sv
test/tb_top.sv
